// ===== rtl/pvc_pkg.sv =====
package pvc_pkg;

    localparam int TARGET_W = 16;
    localparam int GAIN_W   = 8;
    localparam int PERIOD_W = 7;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int ERR_W    = 16;
    localparam int DRIVE_W  = 8;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd10;

    localparam int PROD_W = ERR_W + GAIN_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam int DIVISOR   = 10;
    localparam int DRIVE_MAX = 127;
    localparam int DRIVE_MIN = -128;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((DRIVE_MAX + 1) * DIVISOR);
    localparam logic [ACC_W-1:0] SAT_LO_MAG = ACC_W'((1 - DRIVE_MIN) * DIVISOR);

    localparam int MAG_W       = 11;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP = 13'd6554;
    localparam int QPROD_W     = MAG_W + RECIP_W;

    typedef logic signed [DRIVE_W-1:0] t_drive;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [ACC_W-1:0]   t_acc;

endpackage

// ===== rtl/pid_velocity_controller.sv =====
// Channel      | Dir | Payload (low bit first)                  | Accepted when
// -------------+-----+------------------------------------------+------------------------------
// s_axis       | in  | tdata: now_ms[31:0], encoder_count[63:32]| s_axis_tvalid & s_axis_tready
// m_axis       | out | tdata: pwm_drive[7:0]                    | m_axis_tvalid & m_axis_tready
// apb          | in  | pwdata: register value, paddr: 4*index   | psel & penable & pwrite
//
// One item per cycle sustained while the output is not stalled; a result passes the input, term,
// sum and output registers in series before it is offered.
// Items whose update is not due are dropped at the term stage and give no result.
// Reset is synchronous and active low; it clears valid flags, history, target and gains, and sets the period to 10.
// A stalled output holds only the stages behind it that are full.
module pid_velocity_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], encoder_count[63:32]
    input  logic [pvc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pwm_drive[7:0]
    output logic [pvc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pvc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pvc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pvc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import pvc_pkg::*;

    logic signed [TARGET_W-1:0] r_target;
    logic signed [GAIN_W-1:0]   r_gain_p;
    logic signed [GAIN_W-1:0]   r_gain_i;
    logic signed [GAIN_W-1:0]   r_gain_d;
    logic [PERIOD_W-1:0]        r_period;

    logic [TIME_W-1:0] r_prev_time;
    logic [ERR_W-1:0]  r_prev_pos;
    logic [ERR_W-1:0]  r_err_sum;
    logic [ERR_W-1:0]  r_prev_err;

    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_now;
    logic [POS_W-1:0]  r_in_pos;

    logic r_term_valid;
    t_err r_term_err;
    t_err r_term_sum;
    t_err r_term_inc;

    logic r_acc_valid;
    t_acc r_acc;

    logic   r_out_valid;
    t_drive r_out;

    logic out_rdy, acc_rdy, term_rdy, in_rdy;
    logic cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic [ERR_W-1:0]  vel, n_err, n_inc, n_sum;

    logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
    t_acc acc_sum;

    logic               acc_neg;
    logic [ACC_W-1:0]   acc_mag;
    logic [QPROD_W-1:0] qprod;
    logic [DRIVE_W-1:0] quot;
    t_drive             drive;

    assign out_rdy  = !r_out_valid || m_axis_tready;
    assign acc_rdy  = !r_acc_valid || out_rdy;
    assign term_rdy = !r_term_valid || acc_rdy;
    assign in_rdy   = !r_in_valid || term_rdy;

    assign s_axis_tready = in_rdy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_period <= PERIOD_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TARGET: r_target <= pwdata[TARGET_W-1:0];
                REG_GAIN_P: r_gain_p <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: r_gain_i <= pwdata[GAIN_W-1:0];
                REG_GAIN_D: r_gain_d <= pwdata[GAIN_W-1:0];
                REG_PERIOD: r_period <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TARGET: prdata = APB_DATA_W'(r_target);
            REG_GAIN_P: prdata = APB_DATA_W'(r_gain_p);
            REG_GAIN_I: prdata = APB_DATA_W'(r_gain_i);
            REG_GAIN_D: prdata = APB_DATA_W'(r_gain_d);
            REG_PERIOD: prdata = APB_DATA_W'(r_period);
            default:    prdata = '0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_rdy) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && in_rdy) begin
            r_in_now <= s_axis_tdata[TIME_W-1:0];
            r_in_pos <= s_axis_tdata[TIME_W+POS_W-1:TIME_W];
        end
    end

    // error terms and history update
    assign elapsed = r_in_now - r_prev_time;
    assign due     = elapsed > TIME_W'(r_period);
    assign vel     = r_in_pos[ERR_W-1:0] - r_prev_pos;
    assign n_err   = r_target - vel;
    assign n_inc   = n_err - r_prev_err;
    assign n_sum   = r_err_sum + n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_valid <= 1'b0;
            r_prev_time  <= '0;
            r_prev_pos   <= '0;
            r_err_sum    <= '0;
            r_prev_err   <= '0;
        end else if (term_rdy) begin
            r_term_valid <= r_in_valid && due;
            if (r_in_valid && due) begin
                r_prev_time <= r_in_now;
                r_prev_pos  <= r_in_pos[ERR_W-1:0];
                r_err_sum   <= n_sum;
                r_prev_err  <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (term_rdy && r_in_valid && due) begin
            r_term_err <= n_err;
            r_term_sum <= n_sum;
            r_term_inc <= n_inc;
        end
    end

    // weighted sum
    assign prod_p  = r_term_err * r_gain_p;
    assign prod_i  = r_term_sum * r_gain_i;
    assign prod_d  = r_term_inc * r_gain_d;
    assign acc_sum = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
        end else if (acc_rdy) begin
            r_acc_valid <= r_term_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_rdy && r_term_valid) begin
            r_acc <= acc_sum;
        end
    end

    // divide by ten toward zero and saturate
    assign acc_neg = r_acc[ACC_W-1];
    assign acc_mag = acc_neg ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign qprod   = QPROD_W'(acc_mag[MAG_W-1:0]) * QPROD_W'(RECIP);
    assign quot    = qprod[RECIP_SHIFT+DRIVE_W-1:RECIP_SHIFT];

    always_comb begin
        if (!acc_neg) begin
            drive = (r_acc >= SAT_HI) ? t_drive'(DRIVE_MAX) : t_drive'(quot);
        end else begin
            drive = (acc_mag >= SAT_LO_MAG) ? t_drive'(DRIVE_MIN) : t_drive'(-quot);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= r_acc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_acc_valid) begin
            r_out <= drive;
        end
    end

    a_hold_when_not_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && term_rdy && !due) |=> ($stable(r_prev_time) && $stable(r_err_sum)))
        else $error("history changed on an item with no update due");

    a_due_gives_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && term_rdy && due) |=> (r_term_valid && r_prev_time == $past(r_in_now)))
        else $error("due item did not reach the term stage");

    a_sat_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_valid && out_rdy && !acc_neg && r_acc >= SAT_HI)
        |=> (r_out == t_drive'(DRIVE_MAX)))
        else $error("positive overflow not clamped");

    a_sat_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_valid && out_rdy && acc_neg && acc_mag >= SAT_LO_MAG)
        |=> (r_out == t_drive'(DRIVE_MIN)))
        else $error("negative overflow not clamped");

endmodule
